[sv/tcw_pkg.sv]
`default_nettype none

package tcw_pkg;

    // Default screen geometry
    localparam int unsigned TCW_COLS = 80;
    localparam int unsigned TCW_ROWS = 25;

    // Attribute used by a clear until software writes another one
    localparam logic [7:0] TCW_CLEAR_ATTR_RST = 8'd15;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    // Request item
    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  character;
        logic [7:0]  attribute;
        logic [10:0] read_cell;
    } tcw_req_t;

    // Result item
    typedef struct packed {
        logic [10:0] cursor_cell;
        logic        scrolled;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
    } tcw_rsp_t;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR
    } tcw_state_t;

endpackage

`default_nettype wire

[sv/text_console_writer.sv]
`default_nettype none

// Text console writer: a ROWS x COLS store of character/attribute cells and
// a cursor.
// Requests enter on req when start is high and busy is low. Each request
// gives exactly one result item on rsp, marked by a one-cycle done pulse; the
// receiver cannot hold results off, so a result is simply shown for one cycle.
// Path from the accepting edge to the done pulse:
//   put, newline, backspace without scroll, out-of-range read, unused code: done is
//     registered from the idle state (a new request may be taken in the very next cycle)
//   in-range read of one cell: registered memory read, then ST_READ gives the cell
//   any request that scrolls: ST_SCROLL blanks the row, one memory write
//     per cell of that row
//   clear screen: ST_CLEAR makes one memory write per cell
// The rate is set by the single write port of the cell memory. Scrolling
// does not move cells: the rows form a ring and a base offset names the
// physical start of the top row, so a scroll blanks only one row.
// After reset the block runs a pass that zeroes every cell of the cell
// memory; busy stays high during it. The clear attribute register is written
// through cfg_we/cfg_wdata at any edge and resets to 15.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned COLS = TCW_COLS,
    parameter int unsigned ROWS = TCW_ROWS
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire tcw_req_t   req,
    output      logic       done,
    output      tcw_rsp_t   rsp,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata
);

    localparam int unsigned CELLS = COLS * ROWS;
    localparam int unsigned AW    = $clog2(CELLS);
    localparam int unsigned CW    = $clog2(CELLS + 1);
    localparam int unsigned KW    = $clog2(COLS);
    localparam int unsigned RW    = $clog2(ROWS + 1);
    localparam int unsigned SW    = ((CW > 11) ? CW : 11) + 1;

    tcw_state_t     state_reg, state_next;
    logic [CW-1:0]  cursor_reg, cursor_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [KW-1:0]  col_reg, col_next;
    logic [AW-1:0]  base_reg, base_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic           pend_put_reg, pend_put_next;
    logic [7:0]     pend_char_reg, pend_char_next;
    logic [7:0]     pend_attr_reg, pend_attr_next;
    logic [7:0]     clr_attr_reg;
    logic           done_reg, done_next;
    tcw_rsp_t       rsp_reg, rsp_next;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [15:0]    ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [15:0]    ram_rdata;

    logic [SW-1:0]  logical_idx;
    logic [AW-1:0]  phys_idx;
    logic [CW-1:0]  cursor_dec;
    logic           at_end;
    logic           rd_in_range;

    // Map a logical cell index onto the row ring
    function automatic logic [AW-1:0] to_phys(input logic [SW-1:0] lidx,
                                              input logic [AW-1:0] base);
        logic [SW-1:0] sum;
        sum = lidx + SW'(base);
        if (sum >= SW'(CELLS))
        begin
            sum = sum - SW'(CELLS);
        end
        return AW'(sum);
    endfunction

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cursor_dec  = cursor_reg - CW'(1);
    assign at_end      = (cursor_reg == CW'(CELLS));
    assign rd_in_range = (SW'(req.read_cell) < SW'(CELLS));

    // Pick the logical cell the idle cycle touches
    always_comb
    begin
        logical_idx = SW'(cursor_reg);
        if (req.req_type == REQ_READ)
        begin
            logical_idx = SW'(req.read_cell);
        end
        else if (req.character == CH_BACKSPACE)
        begin
            logical_idx = SW'(cursor_dec);
        end
        phys_idx = to_phys(logical_idx, base_reg);
    end

    assign ram_raddr = phys_idx;

    // Sequence requests, sweeps and results
    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        sweep_next     = sweep_reg;
        pend_put_next  = pend_put_reg;
        pend_char_next = pend_char_reg;
        pend_attr_next = pend_attr_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        ram_we         = 1'b0;
        ram_waddr      = phys_idx;
        ram_wdata      = 16'd0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Zero the cell memory once after reset
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = 16'd0;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    rsp_next.scrolled  = 1'b0;
                    rsp_next.cell_char = 8'd0;
                    rsp_next.cell_attr = 8'd0;
                    unique case (req.req_type)
                        REQ_PUT:
                        begin
                            priority if (req.character == CH_NEWLINE)
                            begin
                                if (row_reg >= RW'(ROWS - 1))
                                begin
                                    pend_put_next = 1'b0;
                                    sweep_next    = base_reg;
                                    state_next    = ST_SCROLL;
                                end
                                else
                                begin
                                    row_next    = row_reg + RW'(1);
                                    col_next    = '0;
                                    cursor_next = cursor_reg - CW'(col_reg) + CW'(COLS);
                                    done_next   = 1'b1;
                                end
                            end
                            else if (req.character == CH_BACKSPACE)
                            begin
                                if (cursor_reg != '0)
                                begin
                                    ram_we      = 1'b1;
                                    ram_wdata   = {req.attribute, CH_SPACE};
                                    cursor_next = cursor_dec;
                                    if (col_reg == '0)
                                    begin
                                        col_next = KW'(COLS - 1);
                                        row_next = row_reg - RW'(1);
                                    end
                                    else
                                    begin
                                        col_next = col_reg - KW'(1);
                                    end
                                end
                                done_next = 1'b1;
                            end
                            else if (at_end)
                            begin
                                pend_put_next  = 1'b1;
                                pend_char_next = req.character;
                                pend_attr_next = req.attribute;
                                sweep_next     = base_reg;
                                state_next     = ST_SCROLL;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_wdata   = {req.attribute, req.character};
                                cursor_next = cursor_reg + CW'(1);
                                if (col_reg == KW'(COLS - 1))
                                begin
                                    col_next = '0;
                                    row_next = row_reg + RW'(1);
                                end
                                else
                                begin
                                    col_next = col_reg + KW'(1);
                                end
                                done_next = 1'b1;
                            end
                        end

                        REQ_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_CLEAR;
                        end

                        REQ_READ:
                        begin
                            if (rd_in_range)
                            begin
                                state_next = ST_READ;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end

                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                // Hand over the cell read in the previous cycle
                rsp_next.cell_char = ram_rdata[7:0];
                rsp_next.cell_attr = ram_rdata[15:8];
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            ST_SCROLL:
            begin
                // Blank the old top row, with any pending character in its first cell; it becomes the bottom row
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = 16'd0;
                if (pend_put_reg && (sweep_reg == base_reg))
                begin
                    ram_wdata = {pend_attr_reg, pend_char_reg};
                end
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == base_reg + AW'(COLS - 1))
                begin
                    if (SW'(base_reg) + SW'(COLS) >= SW'(CELLS))
                    begin
                        base_next = '0;
                    end
                    else
                    begin
                        base_next = base_reg + AW'(COLS);
                    end
                    row_next = RW'(ROWS - 1);
                    if (pend_put_reg)
                    begin
                        cursor_next = CW'(CELLS - COLS + 1);
                        col_next    = KW'(1);
                    end
                    else
                    begin
                        cursor_next = CW'(CELLS - COLS);
                        col_next    = '0;
                    end
                    rsp_next.scrolled = 1'b1;
                    done_next         = 1'b1;
                    state_next        = ST_IDLE;
                end
            end

            ST_CLEAR:
            begin
                // Fill every cell with a space in the clear attribute
                ram_we     = 1'b1;
                ram_waddr  = sweep_reg;
                ram_wdata  = {clr_attr_reg, CH_SPACE};
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(CELLS - 1))
                begin
                    sweep_next  = '0;
                    cursor_next = '0;
                    row_next    = '0;
                    col_next    = '0;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_next.cursor_cell = 11'(cursor_next);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            cursor_reg   <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
            base_reg     <= '0;
            sweep_reg    <= '0;
            pend_put_reg <= 1'b0;
            done_reg     <= 1'b0;
            clr_attr_reg <= TCW_CLEAR_ATTR_RST;
        end
        else
        begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            base_reg     <= base_next;
            sweep_reg    <= sweep_next;
            pend_put_reg <= pend_put_next;
            done_reg     <= done_next;
            if (cfg_we)
            begin
                clr_attr_reg <= cfg_wdata;
            end
        end
    end

    // Hold payload
    always_ff @(posedge clk)
    begin
        pend_char_reg <= pend_char_next;
        pend_attr_reg <= pend_attr_next;
        rsp_reg       <= rsp_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

[sv/tcw_ram.sv]
`default_nettype none

module tcw_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output      logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with a registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb
    import tcw_pkg::*;
();

    localparam int unsigned COLS           = TCW_COLS;
    localparam int unsigned ROWS           = TCW_ROWS;
    localparam int unsigned CELL_COUNT     = COLS * ROWS;
    localparam int unsigned WATCHDOG_LIMIT = 10000;
    localparam int unsigned PHASE_COUNT    = 5;
    localparam int unsigned PHASE_ITEMS    = 387;

    // Request code that the block must ignore
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Console state mirror: predicts one result item per request
    class console_scoreboard;
        logic [15:0] cells [CELL_COUNT];
        int unsigned cursor;
        logic [7:0]  clear_attr;
        tcw_rsp_t    expected_q [$];
        int unsigned errors;

        function new();
            foreach (cells[i])
                cells[i] = '0;
            cursor     = 0;
            clear_attr = TCW_CLEAR_ATTR_RST;
            errors     = 0;
        endfunction

        function void set_clear_attr(logic [7:0] attr);
            clear_attr = attr;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Shift rows up, blank the last row, park the cursor at its start
        function void scroll_up();
            for (int unsigned i = 0; i + COLS < CELL_COUNT; i++)
                cells[i] = cells[i + COLS];
            for (int unsigned i = CELL_COUNT - COLS; i < CELL_COUNT; i++)
                cells[i] = '0;
            cursor = CELL_COUNT - COLS;
        endfunction

        function void note_request(tcw_req_t r);
            tcw_rsp_t e;
            e = '0;
            case (r.req_type)
                REQ_PUT:
                begin
                    if (r.character == CH_NEWLINE)
                    begin
                        if (cursor / COLS >= ROWS - 1)
                        begin
                            scroll_up();
                            e.scrolled = 1'b1;
                        end
                        else
                            cursor = (cursor / COLS + 1) * COLS;
                    end
                    else if (r.character == CH_BACKSPACE)
                    begin
                        if (cursor >= 1)
                        begin
                            cursor--;
                            cells[cursor] = {r.attribute, CH_SPACE};
                        end
                    end
                    else
                    begin
                        if (cursor >= CELL_COUNT)
                        begin
                            scroll_up();
                            e.scrolled = 1'b1;
                        end
                        cells[cursor] = {r.attribute, r.character};
                        cursor++;
                    end
                end
                REQ_CLEAR:
                begin
                    foreach (cells[i])
                        cells[i] = {clear_attr, CH_SPACE};
                    cursor = 0;
                end
                REQ_READ:
                begin
                    if (r.read_cell < CELL_COUNT)
                    begin
                        e.cell_char = cells[r.read_cell][7:0];
                        e.cell_attr = cells[r.read_cell][15:8];
                    end
                end
                default:
                begin
                end
            endcase
            e.cursor_cell = cursor[10:0];
            expected_q.push_back(e);
        endfunction

        function void check_result(tcw_rsp_t got);
            tcw_rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("result item with none expected: cursor_cell %0d", got.cursor_cell);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.cursor_cell !== e.cursor_cell)
            begin
                $error("cursor_cell: expected %0d, got %0d", e.cursor_cell, got.cursor_cell);
                errors++;
            end
            if (got.scrolled !== e.scrolled)
            begin
                $error("scrolled: expected %0d, got %0d", e.scrolled, got.scrolled);
                errors++;
            end
            if (got.cell_char !== e.cell_char)
            begin
                $error("cell_char: expected %0h, got %0h", e.cell_char, got.cell_char);
                errors++;
            end
            if (got.cell_attr !== e.cell_attr)
            begin
                $error("cell_attr: expected %0h, got %0h", e.cell_attr, got.cell_attr);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    tcw_req_t   req_item;
    logic       done;
    tcw_rsp_t   rsp_item;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    console_scoreboard sb = new();
    int unsigned       stall_count;
    int unsigned       items_sent;
    int unsigned       idle_pct;

    text_console_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req_item),
        .done      (done),
        .rsp       (rsp_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Check results, note accepted items, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                sb.check_result(rsp_item);
            if (start && !busy)
                sb.note_request(req_item);
            if (done || (start && !busy))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic tcw_req_t make_req(logic [1:0] kind, logic [7:0] ch,
                                          logic [7:0] attr, logic [10:0] rd_idx);
        tcw_req_t r;
        r.req_type  = kind;
        r.character = ch;
        r.attribute = attr;
        r.read_cell = rd_idx;
        return r;
    endfunction

    function automatic tcw_req_t random_req(logic [1:0] kind);
        return make_req(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        11'($urandom_range(2047)));
    endfunction

    // Hold start low with junk on req for a random gap, then offer the item
    // and wait until it is taken
    task automatic issue(input tcw_req_t r);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start    = 1'b0;
            req_item = random_req(2'($urandom_range(3)));
        end
        @(negedge clk);
        start    = 1'b1;
        req_item = r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic put_char(input logic [7:0] ch, input logic [7:0] attr);
        issue(make_req(REQ_PUT, ch, attr, 11'($urandom_range(2047))));
    endtask

    // Drain all results, then write the clear attribute
    task automatic write_clear_attr(input logic [7:0] attr);
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = attr;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_wdata = 8'($urandom_range(255));
        sb.set_clear_attr(attr);
    endtask

    task automatic run_phase(input int unsigned goal);
        int unsigned pick;
        int unsigned len;
        int unsigned rd_cell;
        issue(random_req(REQ_CLEAR));
        issue(make_req(REQ_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       11'($urandom_range(CELL_COUNT - 1))));
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                // Text line: mostly short, some exactly one row, some wrapping
                len = $urandom_range(99);
                if (len < 60)
                    len = $urandom_range(30);
                else if (len < 75)
                    len = COLS;
                else if (len < 85)
                    len = $urandom_range(COLS + 15, COLS + 1);
                else
                    len = $urandom_range(COLS - 1, 31);
                repeat (len)
                begin
                    if ($urandom_range(9) < 8)
                        put_char(8'($urandom_range(126, 32)), 8'($urandom_range(255)));
                    else
                        put_char(8'($urandom_range(255)), 8'($urandom_range(255)));
                end
                if ($urandom_range(9) < 8)
                    put_char(CH_NEWLINE, 8'($urandom_range(255)));
            end
            else if (pick < 70)
            begin
                repeat ($urandom_range(6, 1))
                    put_char(CH_NEWLINE, 8'($urandom_range(255)));
            end
            else if (pick < 80)
            begin
                repeat ($urandom_range(4, 1))
                    put_char(CH_BACKSPACE, 8'($urandom_range(255)));
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    case ($urandom_range(2))
                        0:       rd_cell = $urandom_range(CELL_COUNT - 1);
                        1:       rd_cell = $urandom_range(2047);
                        default: rd_cell = (sb.cursor == 0) ? 0 : sb.cursor - 1;
                    endcase
                    issue(make_req(REQ_READ, 8'($urandom_range(255)),
                                   8'($urandom_range(255)), 11'(rd_cell)));
                end
            end
            else if (pick < 97)
                issue(random_req(2'($urandom_range(3))));
            else
                issue(random_req(REQ_CLEAR));
        end
    endtask

    initial
    begin
        logic [7:0] attrs [PHASE_COUNT];
        int unsigned pcts [PHASE_COUNT];

        rst_n       = 1'b0;
        start       = 1'b0;
        req_item    = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        stall_count = 0;
        items_sent  = 0;
        idle_pct    = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty screen, out-of-range reads, edges of the fields
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'd0));
        issue(make_req(REQ_READ, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1)));
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'(CELL_COUNT)));
        issue(make_req(REQ_READ, 8'hFF, 8'hFF, 11'h7FF));
        put_char(CH_BACKSPACE, 8'hFF);
        issue(make_req(REQ_UNUSED, 8'hFF, 8'hFF, 11'h7FF));
        put_char(8'h00, 8'h00);
        put_char(8'hFF, 8'hFF);
        put_char(8'hA5, 8'h5A);
        put_char(CH_BACKSPACE, 8'h3C);
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'd0));
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'd1));
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'd2));
        put_char(CH_NEWLINE, 8'h00);
        issue(make_req(REQ_CLEAR, 8'h00, 8'h00, 11'd0));
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'(CELL_COUNT - 1)));
        issue(make_req(REQ_READ, 8'h00, 8'h00, 11'd0));

        // Random phases: clear attribute extremes and several idle rates
        attrs = '{8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255)), 8'h0F};
        pcts  = '{0, 70, 37, 0, 70};
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            idle_pct = 0;
            write_clear_attr(attrs[p]);
            idle_pct = pcts[p];
            run_phase(items_sent + PHASE_ITEMS);
        end

        // Drain and let any stray result show up
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (CELL_COUNT + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer.sv
tb/sv/tb.sv
